[src/assert_macros.svh]
// Assertion macros shared by the RTL, clocked on clk and disabled during arst_n reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/ptd_pkg.sv]
// Shared types and constants for the trial-division prime filter.
`timescale 1ns / 1ps

package ptd_pkg;

	localparam int ELEM_W  = 32;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_NEXT,
		OP_SET_PRIME,
		OP_CLR_PRIME,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_NOT_POSITIVE,
		C_OVER_BOUND,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_OUT_FULL
	} cond_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic not_positive;
		logic over_bound;
		logic div_busy;
		logic rem_zero;
	} dp_stat_t;

	typedef struct packed {
		logic     in_valid;
		logic     out_full;
		dp_stat_t dp;
	} stat_t;

endpackage

[src/ptd_dp.sv]
// Datapath: operand, divisor, divisor square and a radix-4 remainder unit.
`timescale 1ns / 1ps

module ptd_dp
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  op_t               op,
	input  logic              load,
	input  logic [ELEM_W-1:0] in_value,
	output dp_stat_t          stat
);

	localparam int VW     = VALUE_WIDTH;
	localparam int DW     = (VW + 1) / 2 + 1;   // divisor never passes sqrt(v) + 2
	localparam int SW     = 2 * DW;
	localparam int NSTEPS = (VW + 1) / 2;       // two quotient bits per step
	localparam int DVW    = 2 * NSTEPS;
	localparam int CW     = $clog2(NSTEPS + 1);

	logic [VW-1:0]  v_q;
	logic [DW-1:0]  d_q;
	logic [SW-1:0]  sq_q;
	logic [DW-1:0]  rem_q;
	logic [DVW-1:0] dvd_q;
	logic [CW-1:0]  cnt_q;

	logic [DW:0]   r1, r2;
	logic [DW-1:0] m1, m2;

	always_comb begin
		r1 = {rem_q, dvd_q[DVW-1]};
		if (r1 >= {1'b0, d_q}) begin
			m1 = DW'(r1 - {1'b0, d_q});
		end else begin
			m1 = r1[DW-1:0];
		end
		r2 = {m1, dvd_q[DVW-2]};
		if (r2 >= {1'b0, d_q}) begin
			m2 = DW'(r2 - {1'b0, d_q});
		end else begin
			m2 = r2[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q  <= VW'(in_value);
			d_q  <= DW'(2);
			sq_q <= SW'(4);
		end
		case (op)
			OP_DIV_INIT: begin
				rem_q <= '0;
				dvd_q <= DVW'(v_q);
			end
			OP_DIV_STEP: begin
				rem_q <= m2;
				dvd_q <= {dvd_q[DVW-3:0], 2'b00};
			end
			OP_NEXT: begin
				// after 2 only odd divisors are tried
				if (d_q == DW'(2)) begin
					d_q  <= DW'(3);
					sq_q <= SW'(9);
				end else begin
					d_q  <= d_q + DW'(2);
					sq_q <= sq_q + SW'({d_q, 2'b00}) + SW'(4);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (op)
				OP_DIV_INIT: cnt_q <= CW'(NSTEPS - 1);
				OP_DIV_STEP: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.not_positive = v_q[VW-1] | (v_q[VW-1:1] == '0);
	assign stat.over_bound   = sq_q > SW'(v_q);
	assign stat.div_busy     = cnt_q != '0;
	assign stat.rem_zero     = rem_q == '0;

endmodule

[src/ptd_seq.sv]
// Microcode sequencer: program ROM, step counter and conditional jumps.
`timescale 1ns / 1ps

module ptd_seq
	import ptd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	localparam step_t ST_CHK_SMALL = 4'd0;
	localparam step_t ST_CHK_BOUND = 4'd1;
	localparam step_t ST_DIV_INIT  = 4'd2;
	localparam step_t ST_DIV_STEP  = 4'd3;
	localparam step_t ST_TEST      = 4'd4;
	localparam step_t ST_NEXT      = 4'd5;
	localparam step_t ST_PRIME     = 4'd6;
	localparam step_t ST_NOT_PRIME = 4'd7;
	localparam step_t ST_EMIT      = 4'd8;
	localparam step_t ST_IDLE      = 4'd9;

	step_t pc_q;
	step_t pc_next;
	logic  take;

	// program
	always_comb begin
		case (pc_q)
			ST_CHK_SMALL: ctl = '{op: OP_NONE,      cond: C_NOT_POSITIVE, target: ST_NOT_PRIME};
			ST_CHK_BOUND: ctl = '{op: OP_NONE,      cond: C_OVER_BOUND,   target: ST_PRIME};
			ST_DIV_INIT:  ctl = '{op: OP_DIV_INIT,  cond: C_NEVER,        target: ST_DIV_STEP};
			ST_DIV_STEP:  ctl = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY,     target: ST_DIV_STEP};
			ST_TEST:      ctl = '{op: OP_NONE,      cond: C_REM_ZERO,     target: ST_NOT_PRIME};
			ST_NEXT:      ctl = '{op: OP_NEXT,      cond: C_ALWAYS,       target: ST_CHK_BOUND};
			ST_PRIME:     ctl = '{op: OP_SET_PRIME, cond: C_ALWAYS,       target: ST_EMIT};
			ST_NOT_PRIME: ctl = '{op: OP_CLR_PRIME, cond: C_NEVER,        target: ST_EMIT};
			ST_EMIT:      ctl = '{op: OP_EMIT,      cond: C_OUT_FULL,     target: ST_EMIT};
			ST_IDLE:      ctl = '{op: OP_LOAD,      cond: C_NO_INPUT,     target: ST_IDLE};
			default:      ctl = '{op: OP_NONE,      cond: C_ALWAYS,       target: ST_IDLE};
		endcase
	end

	always_comb begin
		case (ctl.cond)
			C_NEVER:        take = 1'b0;
			C_ALWAYS:       take = 1'b1;
			C_NO_INPUT:     take = !stat.in_valid;
			C_NOT_POSITIVE: take = stat.dp.not_positive;
			C_OVER_BOUND:   take = stat.dp.over_bound;
			C_DIV_BUSY:     take = stat.dp.div_busy;
			C_REM_ZERO:     take = stat.dp.rem_zero;
			C_OUT_FULL:     take = stat.out_full;
			default:        take = 1'b0;
		endcase
		if (take) begin
			pc_next = ctl.target;
		end else if (pc_q == ST_IDLE) begin
			pc_next = ST_CHK_SMALL;
		end else begin
			pc_next = pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[src/prime_filter_trial_division.sv]
// Trial-division prime filter. Each input beat carries a signed value (tdata) and an
// end-of-set mark (tlast); each output beat returns the value, a prime flag on tuser and
// the saturating count of primes seen in the set so far, which clears after the set's
// last beat. A small microcoded sequencer runs divisors 2, 3, 5, 7, ... through a
// remainder unit that retires two quotient bits per cycle, and a prime v costs about
// sqrt(v)/2 divisors; values of 1 or less are rejected without trying a divisor. One
// item is in work at a time; the output register frees the sequencer as soon as a
// result is parked, so the next beat is taken while the previous result waits for
// m_tready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prime_filter_trial_division
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ELEM_W-1:0]         s_tdata,   // [31:0] value
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ELEM_W+COUNT_W-1:0] m_tdata,   // [31:0] element, [47:32] kept_count
	output logic                      m_tuser,   // [0] prime_flag
	output logic                      m_tlast
);

	ctl_t  ctl;
	stat_t stat;
	logic  s_accept;
	logic  emit_fire;

	logic [ELEM_W-1:0]  elem_q;
	logic               last_q;
	logic               prime_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] kept;

	logic               m_tvalid_q;
	logic [ELEM_W-1:0]  out_elem_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_prime_q;
	logic               out_last_q;

	assign s_tready  = ctl.op == OP_LOAD;
	assign s_accept  = s_tvalid && s_tready;

	assign stat.in_valid = s_tvalid;
	assign stat.out_full = m_tvalid_q && !m_tready;

	assign emit_fire = (ctl.op == OP_EMIT) && !stat.out_full;

	ptd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ptd_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (ctl.op),
		.load     (s_accept),
		.in_value (s_tdata),
		.stat     (stat.dp)
	);

	assign kept = (prime_q && count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			elem_q <= s_tdata;
			last_q <= s_tlast;
		end
		case (ctl.op)
			OP_SET_PRIME: prime_q <= 1'b1;
			OP_CLR_PRIME: prime_q <= 1'b0;
			default: begin
			end
		endcase
		if (emit_fire) begin
			out_elem_q  <= elem_q;
			out_count_q <= kept;
			out_prime_q <= prime_q;
			out_last_q  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				count_q    <= last_q ? '0 : kept;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_count_q, out_elem_q};
	assign m_tuser  = out_prime_q;
	assign m_tlast  = out_last_q;

	`ASSERT_IMPL(a_prime_has_count, m_tvalid && m_tuser, m_tdata[ELEM_W+COUNT_W-1:ELEM_W] != '0)
	`ASSERT_IMPL(a_prime_positive, emit_fire && prime_q, !stat.dp.not_positive)
	`ASSERT_NEXT(a_set_end_clears, emit_fire && last_q, count_q == '0)
	`ASSERT_NEXT(a_one_in_flight, s_accept, !s_tready)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the trial-division prime filter: directed, pressure and random tests.
`timescale 1ns / 1ps

module testbench
	import ptd_pkg::*;
();

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 4;
	localparam int RANDOM_ITEMS    = 65;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 40;
	localparam int CYCLE_LIMIT     = 4000000;
	localparam int MAX_PRINTED     = 50;

	typedef struct {
		logic [ELEM_W-1:0]  element;
		logic               prime_flag;
		logic [COUNT_W-1:0] kept_count;
		logic               set_end;
	} filter_result_t;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [ELEM_W-1:0]         s_tdata;
	logic                      s_tlast;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [ELEM_W+COUNT_W-1:0] m_tdata;
	logic                      m_tuser;
	logic                      m_tlast;

	filter_result_t     pending_results[$];
	logic [COUNT_W-1:0] set_primes;
	int                 errors;
	int                 burst_left;
	int                 holdoffs_asked;
	int                 holdoffs_done;
	longint             cycles;

	prime_filter_trial_division i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Trial division over the field read as signed; divisors run while d*d <= v.
	function automatic bit is_prime_value(logic [ELEM_W-1:0] v);
		longint unsigned n;
		longint unsigned d;
		if (v[ELEM_W-1])
			return 1'b0;
		n = v;
		if (n <= 1)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_filter(logic [ELEM_W-1:0] value, logic last_item);
		filter_result_t r;
		r.element    = value;
		r.prime_flag = is_prime_value(value);
		if (r.prime_flag && set_primes != COUNT_MAX)
			set_primes = set_primes + 1'b1;
		r.kept_count = set_primes;
		r.set_end    = last_item;
		if (last_item)
			set_primes = '0;
		pending_results.push_back(r);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		if (errors < MAX_PRINTED)
			$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Drives one beat, with burst pacing, and waits for its handshake.
	task automatic send_item(logic [ELEM_W-1:0] value, logic last_item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last_item;
		burst_left--;
		do @(posedge clk); while (!s_tready);
		predict_filter(value, last_item);
	endtask

	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat, element", m_tdata[ELEM_W-1:0], 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[ELEM_W-1:0] !== want.element)
					report_mismatch("element", $signed(m_tdata[ELEM_W-1:0]),
						$signed(want.element));
				if (m_tuser !== want.prime_flag)
					report_mismatch("prime_flag", m_tuser, want.prime_flag);
				if (m_tdata[ELEM_W+COUNT_W-1:ELEM_W] !== want.kept_count)
					report_mismatch("kept_count", m_tdata[ELEM_W+COUNT_W-1:ELEM_W],
						want.kept_count);
				if (m_tlast !== want.set_end)
					report_mismatch("set_end", m_tlast, want.set_end);
			end
		end
	end

	// Receiver: the stall pattern switches at random among four modes; long hold-off on request.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       phase;
		mode_left = 0;
		phase     = 0;
		mode      = RX_ALWAYS;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoffs_done != holdoffs_asked) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				holdoffs_done++;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= phase[1];
				endcase
			end
		end
	end

	task automatic test_field_extremes();
		// non-positive values, smallest primes, both ends of the range
		send_item(32'sd0, 1'b0);
		send_item(32'sd1, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'sd2, 1'b0);
		send_item(32'sd3, 1'b0);
		send_item(32'sd4, 1'b1);
		send_item(32'h7FFF_FFFF, 1'b0);  // largest value, prime: slow on purpose
		send_item(32'h7FFF_FFFE, 1'b1);
	endtask

	task automatic test_square_bound();
		// exact squares must be caught at d*d == v
		send_item(32'sd9, 1'b0);
		send_item(32'sd25, 1'b0);
		send_item(32'sd49, 1'b0);
		send_item(32'sd1018081, 1'b0);  // 1009 squared
		send_item(32'sd91, 1'b0);
		send_item(32'sd97, 1'b0);
		send_item(32'sd1000003, 1'b1);
	endtask

	task automatic test_set_counting();
		// running count, clear after the set end, sets of one
		send_item(32'sd5, 1'b0);
		send_item(32'sd7, 1'b0);
		send_item(32'sd11, 1'b1);
		send_item(32'sd13, 1'b1);
		send_item(32'sd15, 1'b1);
		send_item(-32'sd7, 1'b0);
		send_item(32'sd17, 1'b1);
	endtask

	task automatic test_output_backpressure();
		int i;
		holdoffs_asked++;
		burst_left = 32;
		for (i = 0; i < 12; i++)
			send_item($urandom_range(2, 600), (i % 5) == 4);
	endtask

	task automatic test_random_stream();
		int                i;
		int                pick;
		logic [ELEM_W-1:0] v;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				v = $urandom_range(0, 3000);
			else if (pick < 65)
				v = $urandom_range(3000, 1 << 20);
			else if (pick < 80)
				v = {1'b1, 31'($urandom_range(0, 32'h7FFF_FFFF))};
			else if (pick < 88)
				v = {1'b0, 31'($urandom_range(0, 32'h7FFF_FFFF)) & 31'h7FFF_FFFE};
			else if (pick < 95)
				v = 32'd3 * $urandom_range(1, 700000000);  // odd or even, factor 3
			else
				v = $urandom_range(0, 2);
			send_item(v, $urandom_range(0, 5) == 0);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		set_primes     = '0;
		errors         = 0;
		burst_left     = 0;
		holdoffs_asked = 0;
		holdoffs_done  = 0;
		cycles         = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_square_bound();
		test_set_counting();
		test_output_backpressure();
		test_random_stream();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
